[hw/rtl/ppau_pkg.sv]
package ppau_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_COUNT   = 24;
    localparam int N_CELLS      = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int STEP_W       = $clog2(ATAN_COUNT);
    localparam int LATENCY      = N_CELLS + 5;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sh26DD3B6A;
    localparam logic signed [15:0] HEAD_LIMIT      = 16'sd16384;
    localparam logic signed [63:0] ROUND_HALF      = 64'sd536870912;

    localparam logic signed [31:0] ATAN_TURN [ATAN_COUNT] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic              opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [15:0] a_theta;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [15:0] b_theta;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_theta;
    } t_out_word;

    typedef struct packed {
        logic              op;
        logic              flip;
        logic signed [31:0] p;
        logic signed [31:0] q;
        logic signed [31:0] ofs_x;
        logic signed [31:0] ofs_y;
        logic signed [15:0] theta;
    } t_side;

    typedef struct packed {
        logic              vld;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        t_side             side;
    } t_stage;

endpackage

[hw/rtl/ppau_prep.sv]
module ppau_prep
    import ppau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_word i_in,
    output t_stage   o_stage
);

    t_stage r_stage;
    t_stage n_stage;
    logic   flip;
    logic signed [15:0] head;

    always_comb begin
        flip = (i_in.a_theta > HEAD_LIMIT) || (i_in.a_theta < -HEAD_LIMIT);
        head = flip ? {~i_in.a_theta[15], i_in.a_theta[14:0]} : i_in.a_theta;

        n_stage           = '0;
        n_stage.vld       = i_take;
        n_stage.x         = CORDIC_GAIN_Q30;
        n_stage.y         = '0;
        n_stage.z         = {head, 16'h0000};
        n_stage.side.op   = i_in.opcode;
        n_stage.side.flip = flip;
        if (i_in.opcode) begin
            n_stage.side.p     = i_in.b_x;
            n_stage.side.q     = i_in.b_y;
            n_stage.side.ofs_x = i_in.a_x;
            n_stage.side.ofs_y = i_in.a_y;
            n_stage.side.theta = i_in.a_theta + i_in.b_theta;
        end else begin
            n_stage.side.p     = i_in.b_x - i_in.a_x;
            n_stage.side.q     = i_in.b_y - i_in.a_y;
            n_stage.side.ofs_x = '0;
            n_stage.side.ofs_y = '0;
            n_stage.side.theta = i_in.b_theta - i_in.a_theta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[hw/rtl/ppau_cordic_cell.sv]
module ppau_cordic_cell
    import ppau_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_step  i_step,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage r_stage;
    t_stage n_stage;
    logic signed [31:0] dx;
    logic signed [31:0] dy;

    always_comb begin
        dx      = i_stage.y >>> i_step;
        dy      = i_stage.x >>> i_step;
        n_stage = i_stage;
        if (!i_stage.z[31]) begin
            n_stage.x = i_stage.x - dx;
            n_stage.y = i_stage.y + dy;
            n_stage.z = i_stage.z - ATAN_TURN[i_step];
        end else begin
            n_stage.x = i_stage.x + dx;
            n_stage.y = i_stage.y - dy;
            n_stage.z = i_stage.z + ATAN_TURN[i_step];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[hw/rtl/ppau_mix.sv]
module ppau_mix
    import ppau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stage    i_stage,
    output logic      o_done,
    output t_out_word o_out
);

    typedef struct packed {
        logic              vld;
        logic signed [31:0] c;
        logic signed [31:0] sg;
        logic signed [31:0] p;
        logic signed [31:0] q;
        logic signed [31:0] ofs_x;
        logic signed [31:0] ofs_y;
        logic signed [15:0] theta;
    } t_trig;

    typedef struct packed {
        logic              vld;
        logic signed [63:0] pc;
        logic signed [63:0] qs;
        logic signed [63:0] qc;
        logic signed [63:0] ps;
        logic signed [31:0] ofs_x;
        logic signed [31:0] ofs_y;
        logic signed [15:0] theta;
    } t_prod;

    typedef struct packed {
        logic              vld;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] ofs_x;
        logic signed [31:0] ofs_y;
        logic signed [15:0] theta;
    } t_rot;

    t_trig r_trig, n_trig;
    t_prod r_prod, n_prod;
    t_rot  r_rot,  n_rot;
    logic      r_done;
    t_out_word r_out, n_out;
    logic signed [31:0] s_val;
    logic signed [63:0] acc_x;
    logic signed [63:0] acc_y;

    always_comb begin
        n_trig.vld   = i_stage.vld;
        n_trig.c     = i_stage.side.flip ? -i_stage.x : i_stage.x;
        s_val        = i_stage.side.flip ? -i_stage.y : i_stage.y;
        n_trig.sg    = i_stage.side.op ? s_val : -s_val;
        n_trig.p     = i_stage.side.p;
        n_trig.q     = i_stage.side.q;
        n_trig.ofs_x = i_stage.side.ofs_x;
        n_trig.ofs_y = i_stage.side.ofs_y;
        n_trig.theta = i_stage.side.theta;
    end

    always_comb begin
        n_prod.vld   = r_trig.vld;
        n_prod.pc    = r_trig.p * r_trig.c;
        n_prod.qs    = r_trig.q * r_trig.sg;
        n_prod.qc    = r_trig.q * r_trig.c;
        n_prod.ps    = r_trig.p * r_trig.sg;
        n_prod.ofs_x = r_trig.ofs_x;
        n_prod.ofs_y = r_trig.ofs_y;
        n_prod.theta = r_trig.theta;
    end

    always_comb begin
        acc_x       = r_prod.pc + r_prod.qs + ROUND_HALF;
        acc_y       = r_prod.qc - r_prod.ps + ROUND_HALF;
        n_rot.vld   = r_prod.vld;
        n_rot.rx    = acc_x[61:30];
        n_rot.ry    = acc_y[61:30];
        n_rot.ofs_x = r_prod.ofs_x;
        n_rot.ofs_y = r_prod.ofs_y;
        n_rot.theta = r_prod.theta;
    end

    always_comb begin
        n_out.out_x     = r_rot.ofs_x + r_rot.rx;
        n_out.out_y     = r_rot.ofs_y + r_rot.ry;
        n_out.out_theta = r_rot.theta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig.vld <= 1'b0;
            r_prod.vld <= 1'b0;
            r_rot.vld  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_trig <= n_trig;
            r_prod <= n_prod;
            r_rot  <= n_rot;
            r_out  <= n_out;
            r_done <= r_rot.vld;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

[hw/rtl/planar_pose_algebra_unit.sv]
// channel   ports                  word        handshake
// request   start, busy, i_in      t_in_word   taken when start && !busy
// result    o_done, o_out          t_out_word  valid for the single cycle o_done is high
//
// A request is taken every cycle; busy stays low.
// Each request passes, in order, through the pipeline registers:
// one prep register, one CORDIC cell per step, then trig, multiply, round and offset stages.
// i_rst_n is synchronous and clears all stage valid bits; data registers are not reset.
// The receiver cannot stall; results leave in request order, one per cycle at most.
module planar_pose_algebra_unit
    import ppau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_in,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_out
);

    t_stage w_stage [N_CELLS+1];

    assign busy = 1'b0;

    ppau_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !busy),
        .i_in    (i_in),
        .o_stage (w_stage[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        ppau_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(g)),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    ppau_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage[N_CELLS]),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/ppau_chk.sv]
module ppau_chk
    import ppau_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_word  i_in,
    input logic      busy,
    input logic      o_done,
    input t_out_word o_out
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("request lost");

    a_result_had_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without request");

    a_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.out_theta == ($past(i_in.opcode, LATENCY)
            ? 16'($past(i_in.a_theta, LATENCY) + $past(i_in.b_theta, LATENCY))
            : 16'($past(i_in.b_theta, LATENCY) - $past(i_in.a_theta, LATENCY)))))
        else $error("heading mismatch");

endmodule

bind planar_pose_algebra_unit ppau_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_in    (i_in),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);
